// ----- rtl/sss_pkg.sv -----
package sss_pkg;

    // field and accumulator widths
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 29;
    localparam int SQ_W     = 52;
    localparam int EVEN_W   = 28;
    localparam int CNT_W    = 6;
    localparam int HALF_W   = CNT_W - 1;
    localparam int VAR_W    = 34;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 12;

    // divider: dividend n*Q - S*S + den/2, divisor n*n*4096
    localparam int NUM_W = 57;
    localparam int DSR_W = 23;

    localparam int MAX_ELEMENTS_DEF = 32;

    localparam logic [VAR_W-1:0] VAR_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_NO_EVEN  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MUL,
        ST_DIFF,
        ST_RND,
        ST_VDIV_GO,
        ST_VDIV,
        ST_MDIV_GO,
        ST_MDIV,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic accum;     // input beat taken, update accumulators
        logic fin_mul;   // form n*Q, S*S, n*n*4096
        logic fin_diff;  // n*Q - S*S, floored at zero
        logic fin_rnd;   // add half the divisor
        logic div_start;
        logic div_mean;  // divider operands: even mean instead of variance
        logic cap_var;   // keep variance quotient
        logic load_out;  // fill output register and clear for next set
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic even_none;
    } t_sts;

endpackage

// ----- rtl/sss_in_if.sv -----
interface sss_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sss_pkg::SAMPLE_W-1:0]  sample;
    logic                                 last;

    modport source(output valid, sample, last, input ready);
    modport sink(input valid, sample, last, output ready);
endinterface

// ----- rtl/sss_out_if.sv -----
interface sss_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sss_pkg::SAMPLE_W-1:0]  maximum;
    logic signed [sss_pkg::SAMPLE_W-1:0]  minimum;
    logic signed [sss_pkg::SAMPLE_W-1:0]  even_mean;
    logic        [sss_pkg::VAR_W-1:0]     variance;
    logic        [sss_pkg::CNT_W-1:0]     element_count;
    logic        [sss_pkg::STATUS_W-1:0]  status;

    modport source(output valid, maximum, minimum, even_mean, variance, element_count,
                   status, input ready);
    modport sink(input valid, maximum, minimum, even_mean, variance, element_count,
                 status, output ready);
endinterface

// ----- rtl/sss_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sss_pkg::NUM_W-1:0]   i_dividend,
    input  logic [sss_pkg::DSR_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [sss_pkg::NUM_W-1:0]   o_quotient
);
    localparam int NUM_W  = sss_pkg::NUM_W;
    localparam int DSR_W  = sss_pkg::DSR_W;
    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DSR_W-1:0]  r_rem, n_rem;
    logic [DSR_W-1:0]  r_dsr, n_dsr;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DSR_W:0]    w_trial;
    logic              w_fits;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem  = w_fits ? DSR_W'(w_trial - {1'b0, r_dsr}) : w_trial[DSR_W-1:0];
            n_quo  = {r_quo[NUM_W-2:0], w_fits};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- rtl/sss_dpath.sv -----
// Accumulators, end-of-set arithmetic and output register.
module sss_dpath #(
    parameter int MAX_ELEMENTS = sss_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sss_pkg::t_cmd                       i_cmd,
    output sss_pkg::t_sts                       o_sts,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [sss_pkg::SAMPLE_W-1:0] o_maximum,
    output logic signed [sss_pkg::SAMPLE_W-1:0] o_minimum,
    output logic signed [sss_pkg::SAMPLE_W-1:0] o_even_mean,
    output logic        [sss_pkg::VAR_W-1:0]    o_variance,
    output logic        [sss_pkg::CNT_W-1:0]    o_element_count,
    output logic        [sss_pkg::STATUS_W-1:0] o_status
);
    localparam int SAMPLE_W = sss_pkg::SAMPLE_W;
    localparam int SUM_W    = sss_pkg::SUM_W;
    localparam int SQ_W     = sss_pkg::SQ_W;
    localparam int EVEN_W   = sss_pkg::EVEN_W;
    localparam int CNT_W    = sss_pkg::CNT_W;
    localparam int HALF_W   = sss_pkg::HALF_W;
    localparam int VAR_W    = sss_pkg::VAR_W;
    localparam int FRAC_W   = sss_pkg::FRAC_W;
    localparam int NUM_W    = sss_pkg::NUM_W;
    localparam int DSR_W    = sss_pkg::DSR_W;

    // accumulators
    logic signed [SAMPLE_W-1:0] r_max, r_min;
    logic signed [SUM_W-1:0]    r_sum;
    logic        [SQ_W-1:0]     r_sq;
    logic signed [EVEN_W-1:0]   r_even;
    logic        [CNT_W-1:0]    r_cnt;
    logic                       r_ovf;

    // end-of-set terms
    logic [NUM_W-1:0] r_a, r_b, r_num, r_dvd;
    logic [DSR_W-1:0] r_den;
    logic [NUM_W-1:0] r_var_q;

    // output register
    logic signed [SAMPLE_W-1:0] r_o_max, r_o_min, r_o_mean;
    logic        [VAR_W-1:0]    r_o_var;
    logic        [CNT_W-1:0]    r_o_cnt;
    sss_pkg::t_status           r_o_status;

    logic                       w_room;
    logic        [SAMPLE_W-1:0] w_xmag;
    logic        [2*SAMPLE_W-1:0] w_xsq;
    logic        [SUM_W-1:0]    w_smag;
    logic        [EVEN_W-1:0]   w_emag;
    logic        [HALF_W-1:0]   w_even_n;
    logic        [CNT_W+SQ_W-1:0] w_prod_a;
    logic        [2*SUM_W-1:0]  w_prod_b;
    logic        [2*CNT_W-1:0]  w_nn;
    logic        [EVEN_W-1:0]   w_mdvd;
    logic        [NUM_W-1:0]    w_div_dvd;
    logic        [DSR_W-1:0]    w_div_dsr;
    logic                       w_div_done;
    logic        [NUM_W-1:0]    w_quo;
    logic        [SAMPLE_W-1:0] w_mq;
    logic                       w_var_sat;

    assign w_room   = (r_cnt < CNT_W'(MAX_ELEMENTS));
    assign w_xmag   = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : i_sample;
    assign w_xsq    = w_xmag * w_xmag;
    assign w_smag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
    assign w_emag   = r_even[EVEN_W-1] ? EVEN_W'(-r_even) : r_even;
    assign w_even_n = r_cnt[CNT_W-1:1];
    assign w_prod_a = r_cnt * r_sq;
    assign w_prod_b = w_smag * w_smag;
    assign w_nn     = r_cnt * r_cnt;
    assign w_mdvd   = w_emag + EVEN_W'(w_even_n >> 1);

    assign o_sts.even_none = (w_even_n == '0);
    assign o_sts.div_done  = w_div_done;

    // accumulation, cleared on reset and when a result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_max  <= '0;
            r_min  <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_even <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.accum) begin
            if (w_room) begin
                if (r_cnt == '0 || i_sample > r_max) begin
                    r_max <= i_sample;
                end
                if (r_cnt == '0 || i_sample < r_min) begin
                    r_min <= i_sample;
                end
                r_sum <= r_sum + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
                r_sq  <= r_sq + SQ_W'(w_xsq);
                r_cnt <= r_cnt + 1'b1;
                // this beat lands on an even position
                if (r_cnt[0]) begin
                    r_even <= r_even + {{(EVEN_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_mul) begin
            r_a   <= w_prod_a[NUM_W-1:0];
            r_b   <= w_prod_b[NUM_W-1:0];
            r_den <= {w_nn[DSR_W-FRAC_W-1:0], FRAC_W'(0)};
        end
        if (i_cmd.fin_diff) begin
            r_num <= (r_a > r_b) ? (r_a - r_b) : '0;
        end
        if (i_cmd.fin_rnd) begin
            r_dvd <= r_num + NUM_W'(r_den >> 1);
        end
        if (i_cmd.cap_var) begin
            r_var_q <= w_quo;
        end
    end

    assign w_div_dvd = i_cmd.div_mean ? NUM_W'(w_mdvd) : r_dvd;
    assign w_div_dsr = i_cmd.div_mean ? DSR_W'(w_even_n) : r_den;

    sss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_mq      = w_quo[SAMPLE_W-1:0];
    assign w_var_sat = |r_var_q[NUM_W-1:VAR_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_max <= r_max;
            r_o_min <= r_min;
            r_o_cnt <= r_cnt;
            r_o_var <= w_var_sat ? sss_pkg::VAR_MAX : r_var_q[VAR_W-1:0];
            if (w_even_n == '0) begin
                r_o_mean <= '0;
            end else if (r_even[EVEN_W-1]) begin
                r_o_mean <= -w_mq;
            end else begin
                r_o_mean <= w_mq;
            end
            if (r_ovf) begin
                r_o_status <= sss_pkg::STAT_OVERFLOW;
            end else if (w_even_n == '0) begin
                r_o_status <= sss_pkg::STAT_NO_EVEN;
            end else begin
                r_o_status <= sss_pkg::STAT_OK;
            end
        end
    end

    assign o_maximum       = r_o_max;
    assign o_minimum       = r_o_min;
    assign o_even_mean     = r_o_mean;
    assign o_variance      = r_o_var;
    assign o_element_count = r_o_cnt;
    assign o_status        = r_o_status;
endmodule

// ----- rtl/sss_ctrl.sv -----
// Sequencer: accumulate, then the end-of-set steps, then hand over.
module sss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output sss_pkg::t_cmd o_cmd,
    input  sss_pkg::t_sts i_sts
);
    sss_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sss_pkg::ST_ACCUM: begin
                if (i_in_valid && i_in_last) begin
                    n_state = sss_pkg::ST_MUL;
                end
            end
            sss_pkg::ST_MUL:     n_state = sss_pkg::ST_DIFF;
            sss_pkg::ST_DIFF:    n_state = sss_pkg::ST_RND;
            sss_pkg::ST_RND:     n_state = sss_pkg::ST_VDIV_GO;
            sss_pkg::ST_VDIV_GO: n_state = sss_pkg::ST_VDIV;
            sss_pkg::ST_VDIV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.even_none ? sss_pkg::ST_LOAD : sss_pkg::ST_MDIV_GO;
                end
            end
            sss_pkg::ST_MDIV_GO: n_state = sss_pkg::ST_MDIV;
            sss_pkg::ST_MDIV: begin
                if (i_sts.div_done) begin
                    n_state = sss_pkg::ST_LOAD;
                end
            end
            sss_pkg::ST_LOAD: begin
                if (w_slot_free) begin
                    n_state = sss_pkg::ST_ACCUM;
                end
            end
            default: n_state = sss_pkg::ST_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sss_pkg::ST_ACCUM: begin
                o_in_ready  = 1'b1;
                o_cmd.accum = i_in_valid;
            end
            sss_pkg::ST_MUL:     o_cmd.fin_mul  = 1'b1;
            sss_pkg::ST_DIFF:    o_cmd.fin_diff = 1'b1;
            sss_pkg::ST_RND:     o_cmd.fin_rnd  = 1'b1;
            sss_pkg::ST_VDIV_GO: o_cmd.div_start = 1'b1;
            sss_pkg::ST_VDIV:    o_cmd.cap_var  = i_sts.div_done;
            sss_pkg::ST_MDIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mean  = 1'b1;
            end
            sss_pkg::ST_MDIV: ;
            sss_pkg::ST_LOAD:    o_cmd.load_out = w_slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sss_pkg::ST_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/sample_set_statistics.sv -----
// Sample set statistics. Signed Q12.12 samples arrive one beat per cycle on
// i_in, the final sample of a set flagged by last. Only the first
// MAX_ELEMENTS samples of a set count; extra ones are dropped and the result
// carries status 1. After the last beat one result beat leaves on o_out:
// maximum, minimum, the mean of the samples at even positions (second,
// fourth, ...; rounded to nearest, ties away from zero, 0 with status 2 for a
// one-sample set), the population variance around the mean of all samples
// in Q22.12 (rounded, saturating at all ones) and the sample count.
// Samples stream at one beat per cycle. After the last beat the input stalls
// for the end-of-set steps and the shared one-bit-per-cycle divider, which
// does the 57-bit variance division and then, when there is an even mean to
// form, the mean division.
// The result sits in an output register, so the next set may start while it
// waits to be taken; only a second finished set waits for it.
module sample_set_statistics #(
    parameter int MAX_ELEMENTS = sss_pkg::MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_out
);
    sss_pkg::t_cmd w_cmd;
    sss_pkg::t_sts w_sts;

    // sequencer
    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // accumulators, end-of-set arithmetic, divider and result register
    sss_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_sample        (i_in.sample),
        .o_maximum       (o_out.maximum),
        .o_minimum       (o_out.minimum),
        .o_even_mean     (o_out.even_mean),
        .o_variance      (o_out.variance),
        .o_element_count (o_out.element_count),
        .o_status        (o_out.status)
    );
endmodule

// ----- rtl/sss_chk.sv -----
module sss_chk #(
    parameter int MAX_ELEMENTS = sss_pkg::MAX_ELEMENTS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [sss_pkg::SAMPLE_W-1:0] i_maximum,
    input logic signed [sss_pkg::SAMPLE_W-1:0] i_minimum,
    input logic        [sss_pkg::VAR_W-1:0]    i_variance,
    input logic        [sss_pkg::CNT_W-1:0]    i_element_count,
    input logic        [sss_pkg::STATUS_W-1:0] i_status
);
    // a held result beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_variance)
            && $stable(i_maximum) && $stable(i_element_count))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_element_count != '0
            && i_element_count <= sss_pkg::CNT_W'(MAX_ELEMENTS))
        else $error("element count out of range");

    a_max_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_maximum >= i_minimum)
        else $error("maximum below minimum");

    // all samples equal: no spread
    a_flat_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_maximum == i_minimum |-> i_variance == '0)
        else $error("non-zero variance of a flat set");

    a_no_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == sss_pkg::STAT_NO_EVEN |-> i_element_count == 1)
        else $error("no-even status on a set of more than one sample");
endmodule

bind sample_set_statistics sss_chk #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_sss_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_maximum       (o_out.maximum),
    .i_minimum       (o_out.minimum),
    .i_variance      (o_out.variance),
    .i_element_count (o_out.element_count),
    .i_status        (o_out.status)
);

// ----- bench/sample_set_statistics_test.sv -----
module sample_set_statistics_test;
    import sss_pkg::*;

    localparam int MAX_SET      = MAX_ELEMENTS_DEF;
    localparam int ITEM_TARGET  = 1800;
    localparam int IDLE_PCT     = 21;
    // Slowest legal run: every beat a one-sample set, with every result
    // waiting out a stall, plus the long hold-off. That comes to well under
    // this limit.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = 160;
    // Both sides run flat out inside this window.
    localparam int CALM_FROM    = 5000;
    localparam int CALM_TO      = 8000;
    // Receiver goes deaf here long enough for a finished set to sit in the
    // output register and a second one to back up into the input.
    localparam int HOLD_AT      = 2500;
    localparam int HOLD_CYCLES  = 600;

    typedef longint unsigned u64_t;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EXTREME
    } sample_mix_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_beat_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] even_mean;
        logic        [VAR_W-1:0]    variance;
        logic        [CNT_W-1:0]    element_count;
        t_status                    status;
    } set_stats_t;

    logic i_clk;
    logic i_rst_n;

    sss_in_if  in_bus ();
    sss_out_if out_bus ();

    sample_set_statistics #(
        .MAX_ELEMENTS(MAX_SET)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    sample_beat_t pending_beats[$];
    set_stats_t   stats_expected[$];

    int cycle_count;
    int hold_left;
    int error_count;
    int beats_accepted;
    int sets_closed;
    int sets_single;
    int sets_over_capacity;
    int results_checked;

    // Running picture of the set now streaming in.
    longint set_max;
    longint set_min;
    longint set_sum;
    u64_t   set_sq_sum;
    longint set_even_sum;
    int     set_count;
    bit     set_overflowed;

    wire calm_window = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic u64_t magnitude_of(input longint v);
        return (v < 0) ? u64_t'(-v) : u64_t'(v);
    endfunction

    function automatic void clear_running_set();
        set_max        = 0;
        set_min        = 0;
        set_sum        = 0;
        set_sq_sum     = 0;
        set_even_sum   = 0;
        set_count      = 0;
        set_overflowed = 1'b0;
    endfunction

    // Fold one accepted beat into the running set; on the last beat work out
    // the statistics the block must produce and queue them.
    task automatic absorb_beat(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
        longint     x;
        longint     emean;
        u64_t       n;
        u64_t       even_n;
        u64_t       q;
        u64_t       mag_sum;
        u64_t       n_sq_sum;
        u64_t       sum_sq;
        u64_t       num;
        u64_t       den;
        u64_t       var_q;
        set_stats_t r;
        x = longint'(smp);
        if (set_count < MAX_SET) begin
            if (set_count == 0) begin
                set_max = x;
                set_min = x;
            end else begin
                if (x > set_max) set_max = x;
                if (x < set_min) set_min = x;
            end
            set_sum    += x;
            set_sq_sum += magnitude_of(x) * magnitude_of(x);
            set_count++;
            if (set_count % 2 == 0) set_even_sum += x;
        end else begin
            // beyond capacity: dropped, only flagged
            set_overflowed = 1'b1;
        end
        if (!fin) return;

        n      = u64_t'(set_count);
        even_n = n / 2;

        // even mean: round half away from zero, done on the magnitude
        emean = 0;
        if (even_n != 0) begin
            q     = (magnitude_of(set_even_sum) + even_n / 2) / even_n;
            emean = (set_even_sum < 0) ? -longint'(q) : longint'(q);
        end

        // population variance (n*Q - S*S) / (n*n*4096), floored at zero,
        // rounded half up, clipped to the output width
        mag_sum  = magnitude_of(set_sum);
        n_sq_sum = n * set_sq_sum;
        sum_sq   = mag_sum * mag_sum;
        num      = (n_sq_sum > sum_sq) ? n_sq_sum - sum_sq : 0;
        den      = n * n * 4096;
        var_q    = (num + den / 2) / den;
        if (var_q > u64_t'(VAR_MAX)) var_q = u64_t'(VAR_MAX);

        r.maximum       = SAMPLE_W'(set_max);
        r.minimum       = SAMPLE_W'(set_min);
        r.even_mean     = SAMPLE_W'(emean);
        r.variance      = VAR_W'(var_q);
        r.element_count = CNT_W'(n);
        if (set_overflowed)   r.status = STAT_OVERFLOW;
        else if (even_n == 0) r.status = STAT_NO_EVEN;
        else                  r.status = STAT_OK;
        stats_expected.push_back(r);

        sets_closed++;
        if (set_overflowed) sets_over_capacity++;
        if (n == 1)         sets_single++;
        clear_running_set();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    function automatic void add_beat(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
        sample_beat_t b;
        b.sample = smp;
        b.last   = fin;
        pending_beats.push_back(b);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_t mix);
        int unsigned pick;
        pick = $urandom_range(0, 4);
        case (mix)
            MIX_NARROW: begin
                return SAMPLE_W'($urandom_range(0, 8192)) - SAMPLE_W'(4096);
            end
            MIX_EXTREME: begin
                case (pick)
                    0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
                    1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
                    2: return '0;
                    3: return '1;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
            default: begin
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // Sender: offers the next queued beat, holding it until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                beats_accepted++;
                absorb_beat(in_bus.sample, in_bus.last);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_beats.size() != 0 &&
                    (calm_window || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_bus.valid  <= 1'b1;
                    in_bus.sample <= pending_beats[0].sample;
                    in_bus.last   <= pending_beats[0].last;
                    void'(pending_beats.pop_front());
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to look.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (cycle_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: each result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        set_stats_t want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (stats_expected.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual max %0h min %0h",
                             $time, out_bus.maximum, out_bus.minimum);
                    error_count++;
                end else begin
                    want = stats_expected.pop_front();
                    check_field("maximum", want.maximum, out_bus.maximum);
                    check_field("minimum", want.minimum, out_bus.minimum);
                    check_field("even_mean", want.even_mean, out_bus.even_mean);
                    check_field("variance", want.variance, out_bus.variance);
                    check_field("element_count", want.element_count, out_bus.element_count);
                    check_field("status", want.status, out_bus.status);
                    results_checked++;
                end
            end
            out_bus.ready <= (hold_left == 0) &&
                             (calm_window || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still expected", $time, stats_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int          len;
        int unsigned roll;
        sample_mix_t mix;
        bit          first_set;

        in_bus.valid  = 1'b0;
        in_bus.sample = '0;
        in_bus.last   = 1'b0;
        out_bus.ready = 1'b0;
        i_rst_n       = 1'b0;
        cycle_count   = 0;
        error_count   = 0;
        clear_running_set();

        // Directed sets: lone extremes, widest spread both ways round,
        // half-way ties of the even mean in both signs, an odd length,
        // a lone zero and a run at the most negative value.
        add_beat(24'sh7FFFFF, 1'b1);
        add_beat(24'sh800000, 1'b1);
        add_beat(24'sh7FFFFF, 1'b0);
        add_beat(24'sh800000, 1'b1);
        add_beat(24'sh800000, 1'b0);
        add_beat(24'sh7FFFFF, 1'b1);
        add_beat(24'sd0, 1'b0);
        add_beat(24'sd1, 1'b0);
        add_beat(24'sd0, 1'b0);
        add_beat(24'sd2, 1'b1);
        add_beat(24'sd0, 1'b0);
        add_beat(-24'sd1, 1'b0);
        add_beat(24'sd0, 1'b0);
        add_beat(-24'sd2, 1'b1);
        add_beat(24'sd5, 1'b0);
        add_beat(-24'sd7, 1'b0);
        add_beat(24'sd3, 1'b1);
        add_beat(24'sd0, 1'b1);
        for (int i = 0; i < 4; i++) add_beat(24'sh800000, i == 3);

        // Random sets: mostly short or mid-length, a share exactly at
        // capacity, and some over it (the first random set always is).
        first_set = 1'b1;
        while (pending_beats.size() < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (first_set || roll >= 90) len = MAX_SET + $urandom_range(1, 8);
            else if (roll < 35)          len = $urandom_range(1, 4);
            else if (roll < 77)          len = $urandom_range(5, MAX_SET - 1);
            else                         len = MAX_SET;
            first_set = 1'b0;
            roll = $urandom_range(0, 9);
            mix  = (roll < 5) ? MIX_WIDE : (roll < 8) ? MIX_NARROW : MIX_EXTREME;
            for (int i = 0; i < len; i++) add_beat(pick_sample(mix), i == len - 1);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_bus.valid || stats_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Streamed %0d beats in %0d sets: %0d single-sample, %0d over capacity.",
                 beats_accepted, sets_closed, sets_single, sets_over_capacity);
        $display("Compared %0d result beats, %0d field mismatches.",
                 results_checked, error_count);
        if (error_count == 0 && stats_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sss_pkg.sv
rtl/sss_in_if.sv
rtl/sss_out_if.sv
rtl/sss_div.sv
rtl/sss_dpath.sv
rtl/sss_ctrl.sv
rtl/sample_set_statistics.sv
rtl/sss_chk.sv
bench/sample_set_statistics_test.sv
